// ===== design/hfe_pkg.sv =====
// Shared constants, types and helpers of the histogram fill engine.
package hfe_pkg;

  // Sizing of the block.
  localparam int AXES        = 2;
  localparam int MAX_BINS    = 30;
  localparam int COORD_FRAC  = 16;
  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int EDGE_SLOTS  = 32;
  localparam int SLOT_W      = $clog2(EDGE_SLOTS);
  localparam int EDGE_DEPTH  = 2 * EDGE_SLOTS;
  localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
  localparam int MOMENTS     = 7;

  // Derived widths of the axis and moment datapaths.
  localparam int BIN_W   = $clog2(MAX_BINS + 2);
  localparam int QUO_W   = $clog2(MAX_BINS + 1);
  localparam int DIV_IW  = (QUO_W > 1) ? $clog2(QUO_W) : 1;
  localparam int NUM_W   = 32 + BIN_W;
  localparam int FLAT_W  = 2 * BIN_W + 1;
  localparam int SHIFT_W = 64 - COORD_FRAC;
  localparam int HI_W    = SHIFT_W - 32;

  // Saturation limits.
  localparam logic [31:0] SHORT_LIMIT = 32'h00007fff;
  localparam logic [31:0] LONG_LIMIT  = 32'h7fffffff;
  localparam logic [63:0] ACC_MAX     = {1'b0, {63{1'b1}}};
  localparam logic [63:0] ACC_MIN     = {1'b1, 63'd0};

  // Item kinds.
  typedef enum logic [2:0] {
    KIND_FILL     = 3'd0,
    KIND_LOAD     = 3'd1,
    KIND_READ_BIN = 3'd2,
    KIND_READ_MOM = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_BINS_X       = 3'd0,
    CFG_BINS_Y       = 3'd1,
    CFG_X_LOW        = 3'd2,
    CFG_X_HIGH       = 3'd3,
    CFG_Y_LOW        = 3'd4,
    CFG_Y_HIGH       = 3'd5,
    CFG_VARIABLE     = 3'd6,
    CFG_CONTENT_MODE = 3'd7
  } cfg_idx_e;

  // Moment accumulator indexes.
  typedef enum logic [2:0] {
    MOM_SUMW   = 3'd0,
    MOM_SUMW2  = 3'd1,
    MOM_SUMWX  = 3'd2,
    MOM_SUMWX2 = 3'd3,
    MOM_SUMWY  = 3'd4,
    MOM_SUMWY2 = 3'd5,
    MOM_SUMWXY = 3'd6
  } mom_e;

  // Sequencer states.
  typedef enum logic [15:0] {
    S_CLEAR    = 16'h0001,
    S_IDLE     = 16'h0002,
    S_AXIS     = 16'h0004,
    S_SCALE    = 16'h0008,
    S_DIV      = 16'h0010,
    S_SRCH_RD  = 16'h0020,
    S_SRCH_CMP = 16'h0040,
    S_FLAT     = 16'h0080,
    S_BRD      = 16'h0100,
    S_BWR      = 16'h0200,
    S_MUL1     = 16'h0400,
    S_MULLO    = 16'h0800,
    S_MULHI    = 16'h1000,
    S_SATX     = 16'h2000,
    S_MADD     = 16'h4000,
    S_EMIT     = 16'h8000
  } state_e;

  // Configuration registers as seen by the core.
  typedef struct packed {
    logic [4:0]         bins_x;
    logic [4:0]         bins_y;
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic signed [31:0] y_low;
    logic signed [31:0] y_high;
    logic [1:0]         variable_axes;
    logic               content_mode;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] weight;
    logic               edge_axis;
    logic [4:0]         edge_slot;
    logic signed [31:0] edge_value;
    logic [9:0]         bin_address;
    logic [2:0]         moment_select;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [9:0]         flat_bin;
    logic               in_range;
    logic signed [31:0] bin_content;
    logic signed [63:0] moment_value;
  } res_t;

  // Effective bin count: the register clamped to 1..MAX_BINS.
  function automatic logic [BIN_W-1:0] eff_bins(input logic [4:0] r);
    logic [BIN_W-1:0] n;
    if (r == 5'd0) begin
      n = BIN_W'(1);
    end else if (int'(r) > MAX_BINS) begin
      n = BIN_W'(MAX_BINS);
    end else begin
      n = BIN_W'(r);
    end
    return n;
  endfunction

  // Magnitude of a signed 32-bit word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

endpackage

// ===== design/hfe_if.sv =====
// Valid/ready channel interfaces of the histogram fill engine.
interface hfe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] weight;
  logic        edge_axis;
  logic [4:0]  edge_slot;
  logic [31:0] edge_value;
  logic [9:0]  bin_address;
  logic [2:0]  moment_select;

  modport source (output valid, kind, coord_x, coord_y, weight, edge_axis, edge_slot,
                  edge_value, bin_address, moment_select, input ready);
  modport sink (input valid, kind, coord_x, coord_y, weight, edge_axis, edge_slot,
                edge_value, bin_address, moment_select, output ready);
endinterface

interface hfe_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  flat_bin;
  logic        in_range;
  logic [31:0] bin_content;
  logic [63:0] moment_value;

  modport source (output valid, flat_bin, in_range, bin_content, moment_value,
                  input ready);
  modport sink (input valid, flat_bin, in_range, bin_content, moment_value,
                output ready);
endinterface

interface hfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/hfe_ram.sv =====
// Generic single-port RAM with registered read data.
module hfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read before write at the addressed word, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hfe_mul.sv =====
// Shared 32x32 magnitude multiplier with sign fix-up and registered product.
module hfe_mul
  import hfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        neg_i,
  output logic [63:0] prod_o
);

  logic [63:0] mag_prod;
  logic [63:0] prod_d;
  logic [63:0] prod_q;

  // Unsigned product, negated when neg_i is set.
  always_comb begin
    mag_prod = 64'(a_i) * 64'(b_i);
    prod_d   = neg_i ? 64'(-mag_prod) : mag_prod;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== design/hfe_core.sv =====
// Sequencer and datapath: axis binning, bin update and moment accumulation.
module hfe_core
  import hfe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  // Sequencer and datapath registers.
  state_e               state_d, state_q;
  item_t                item_d, item_q;
  logic                 ax_d, ax_q;
  logic [BIN_W-1:0]     bx_d, bx_q, by_d, by_q;
  logic [NUM_W-1:0]     rem_d, rem_q;
  logic [31:0]          den_d, den_q;
  logic [QUO_W-1:0]     quo_d, quo_q;
  logic [DIV_IW-1:0]    step_d, step_q;
  logic [BIN_W-1:0]     below_d, below_q, above_d, above_q, mid_d, mid_q;
  logic [STORE_AW-1:0]  flat_d, flat_q;
  logic                 rd_only_d, rd_only_q;
  logic                 inr_d, inr_q;
  res_t                 res_d, res_q;
  mom_e                 mi_d, mi_q;
  logic                 neg_d, neg_q;
  logic [HI_W-1:0]      shi_d, shi_q;
  logic [63:0]          lo_d, lo_q;
  logic [63:0]          term_d, term_q;
  logic [63:0]          acc_d [MOMENTS];
  logic [63:0]          acc_q [MOMENTS];
  logic [STORE_AW-1:0]  clr_d, clr_q;

  // Combinational helpers.
  logic signed [31:0]   c_val, lo_val, hi_val, e_val;
  logic [BIN_W-1:0]     n_val, nx, ny;
  logic                 var_axis;
  logic                 axis_done;
  logic [BIN_W-1:0]     axis_res;
  logic [NUM_W-1:0]     trial;
  logic [QUO_W-1:0]     quo_nx;
  logic [BIN_W:0]       mid_sum;
  logic [BIN_W-1:0]     mid_val, slot_full;
  logic [SLOT_W-1:0]    slot;
  logic [FLAT_W-1:0]    flat_full;
  logic [33:0]          view_val, new_val, lim;
  logic [31:0]          w_mag;
  logic [SHIFT_W-1:0]   s_val, s_mag;
  logic [95:0]          wide_p;
  logic [63:0]          term;
  logic [64:0]          sum;
  logic                 sat_path;

  // Memory and multiplier ports.
  logic                 bin_we;
  logic [STORE_AW-1:0]  bin_addr;
  logic [31:0]          bin_wdata, bin_rdata;
  logic                 edge_we;
  logic [EDGE_AW-1:0]   edge_addr;
  logic [31:0]          edge_rdata;
  logic                 mul_en, mul_neg;
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          prod;

  hfe_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .addr_i  (bin_addr),
    .wdata_i (bin_wdata),
    .rdata_o (bin_rdata)
  );

  hfe_ram #(.WIDTH(32), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .addr_i  (edge_addr),
    .wdata_i (in_item_i.edge_value),
    .rdata_o (edge_rdata)
  );

  hfe_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .neg_i  (mul_neg),
    .prod_o (prod)
  );

  // Per-axis operands selected by the current axis.
  always_comb begin
    nx       = eff_bins(cfg_i.bins_x);
    ny       = eff_bins(cfg_i.bins_y);
    c_val    = ax_q ? item_q.coord_y : item_q.coord_x;
    lo_val   = ax_q ? cfg_i.y_low : cfg_i.x_low;
    hi_val   = ax_q ? cfg_i.y_high : cfg_i.x_high;
    n_val    = ax_q ? ny : nx;
    var_axis = cfg_i.variable_axes[ax_q];
    e_val    = edge_rdata;
    w_mag    = mag32(item_q.weight);
    sat_path = (mi_q == MOM_SUMWX2) || (mi_q == MOM_SUMWY2) || (mi_q == MOM_SUMWXY);
  end

  // Next-state and datapath logic.
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    ax_d      = ax_q;
    bx_d      = bx_q;
    by_d      = by_q;
    rem_d     = rem_q;
    den_d     = den_q;
    quo_d     = quo_q;
    step_d    = step_q;
    below_d   = below_q;
    above_d   = above_q;
    mid_d     = mid_q;
    flat_d    = flat_q;
    rd_only_d = rd_only_q;
    inr_d     = inr_q;
    res_d     = res_q;
    mi_d      = mi_q;
    neg_d     = neg_q;
    shi_d     = shi_q;
    lo_d      = lo_q;
    term_d    = term_q;
    acc_d     = acc_q;
    clr_d     = clr_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    axis_done   = 1'b0;
    axis_res    = '0;
    bin_we      = 1'b0;
    bin_addr    = flat_q;
    bin_wdata   = '0;
    edge_we     = 1'b0;
    edge_addr   = {in_item_i.edge_axis, in_item_i.edge_slot};
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    mul_neg     = 1'b0;
    trial       = '0;
    quo_nx      = quo_q;
    mid_sum     = '0;
    mid_val     = '0;
    slot_full   = '0;
    slot        = '0;
    flat_full   = '0;
    view_val    = '0;
    new_val     = '0;
    lim         = '0;
    s_val       = '0;
    s_mag       = '0;
    wide_p      = '0;
    term        = '0;
    sum         = '0;

    case (state_q)
      // Sweep zeros through the bin store.
      S_CLEAR: begin
        bin_we   = 1'b1;
        bin_addr = clr_q;
        clr_d    = clr_q + STORE_AW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end

      // Take an item and dispatch on its kind.
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_item_i;
          if (AXES < 2) begin
            item_d.coord_y = '0;
          end
          case (in_item_i.kind)
            KIND_FILL: begin
              ax_d      = 1'b0;
              by_d      = '0;
              rd_only_d = 1'b0;
              state_d   = S_AXIS;
            end
            KIND_LOAD: begin
              edge_we = 1'b1;
            end
            KIND_READ_BIN: begin
              flat_d    = in_item_i.bin_address;
              rd_only_d = 1'b1;
              state_d   = S_BRD;
            end
            KIND_READ_MOM: begin
              res_d = '0;
              if (int'(in_item_i.moment_select) < MOMENTS) begin
                res_d.moment_value = acc_q[in_item_i.moment_select];
              end
              state_d = S_EMIT;
            end
            KIND_CLEAR: begin
              for (int i = 0; i < MOMENTS; i++) begin
                acc_d[i] = '0;
              end
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      // Flow bins, or start of the uniform or searched bin.
      S_AXIS: begin
        if (c_val < lo_val) begin
          axis_done = 1'b1;
          axis_res  = '0;
        end else if (c_val >= hi_val) begin
          axis_done = 1'b1;
          axis_res  = n_val + BIN_W'(1);
        end else if (var_axis) begin
          below_d = '0;
          above_d = n_val + BIN_W'(1);
          state_d = S_SRCH_RD;
        end else begin
          rem_d   = NUM_W'(32'(c_val - lo_val));
          den_d   = 32'(hi_val - lo_val);
          state_d = S_SCALE;
        end
      end

      // Scale the offset by the bin count.
      S_SCALE: begin
        rem_d   = NUM_W'(rem_q[31:0]) * NUM_W'(n_val);
        quo_d   = '0;
        step_d  = DIV_IW'(QUO_W - 1);
        state_d = S_DIV;
      end

      // Restoring division, one quotient bit per cycle.
      S_DIV: begin
        trial = NUM_W'(den_q) << step_q;
        if (rem_q >= trial) begin
          rem_d          = rem_q - trial;
          quo_nx[step_q] = 1'b1;
        end
        quo_d = quo_nx;
        if (step_q == '0) begin
          axis_done = 1'b1;
          axis_res  = BIN_W'(quo_nx) + BIN_W'(1);
        end else begin
          step_d = step_q - DIV_IW'(1);
        end
      end

      // Binary search: read the edge at the midpoint.
      S_SRCH_RD: begin
        if ((BIN_W + 1)'(above_q) > (BIN_W + 1)'(below_q) + (BIN_W + 1)'(1)) begin
          mid_sum   = (BIN_W + 1)'(above_q) + (BIN_W + 1)'(below_q);
          mid_val   = BIN_W'(mid_sum >> 1);
          slot_full = mid_val - BIN_W'(1);
          if (int'(slot_full) > EDGE_SLOTS - 1) begin
            slot = SLOT_W'(EDGE_SLOTS - 1);
          end else begin
            slot = SLOT_W'(slot_full);
          end
          edge_addr = {ax_q, slot};
          mid_d     = mid_val;
          state_d   = S_SRCH_CMP;
        end else begin
          axis_done = 1'b1;
          axis_res  = below_q;
        end
      end

      // Binary search: narrow the interval.
      S_SRCH_CMP: begin
        if (c_val == e_val) begin
          axis_done = 1'b1;
          axis_res  = mid_q;
        end else begin
          if (c_val < e_val) begin
            above_d = mid_q;
          end else begin
            below_d = mid_q;
          end
          state_d = S_SRCH_RD;
        end
      end

      // Flat index and range flag.
      S_FLAT: begin
        flat_full = FLAT_W'(by_q) * FLAT_W'((BIN_W + 1)'(nx) + (BIN_W + 1)'(2))
                  + FLAT_W'(bx_q);
        flat_d    = STORE_AW'(flat_full);
        inr_d     = (bx_q != '0) && (bx_q <= nx) &&
                    ((AXES < 2) || ((by_q != '0) && (by_q <= ny)));
        state_d   = S_BRD;
      end

      // Bin read issued at the flat index.
      S_BRD: begin
        bin_addr = flat_q;
        state_d  = S_BWR;
      end

      // Bin read-modify-write with saturation, or plain read.
      S_BWR: begin
        view_val = cfg_i.content_mode ? {{18{bin_rdata[15]}}, bin_rdata[15:0]}
                                      : {{2{bin_rdata[31]}}, bin_rdata};
        res_d          = '0;
        res_d.flat_bin = flat_q;
        if (rd_only_q) begin
          res_d.bin_content = view_val[31:0];
          state_d           = S_EMIT;
        end else begin
          lim     = cfg_i.content_mode ? {2'b00, SHORT_LIMIT} : {2'b00, LONG_LIMIT};
          new_val = view_val + {{2{item_q.weight[31]}}, item_q.weight};
          if ($signed(new_val) > $signed(lim)) begin
            new_val = lim;
          end else if ($signed(new_val) < -$signed(lim)) begin
            new_val = 34'(-lim);
          end
          bin_we            = 1'b1;
          bin_addr          = flat_q;
          bin_wdata         = new_val[31:0];
          res_d.in_range    = inr_q;
          res_d.bin_content = new_val[31:0];
          if (inr_q) begin
            mi_d    = MOM_SUMW;
            state_d = S_MUL1;
          end else begin
            state_d = S_EMIT;
          end
        end
      end

      // First product of the current moment.
      S_MUL1: begin
        mul_en = 1'b1;
        case (mi_q)
          MOM_SUMW: begin
            mul_a   = w_mag;
            mul_b   = 32'd1;
            mul_neg = item_q.weight[31];
          end
          MOM_SUMW2: begin
            mul_a   = w_mag;
            mul_b   = w_mag;
            mul_neg = 1'b0;
          end
          MOM_SUMWX: begin
            mul_a   = w_mag;
            mul_b   = mag32(item_q.coord_x);
            mul_neg = item_q.weight[31] ^ item_q.coord_x[31];
          end
          MOM_SUMWX2: begin
            mul_a   = mag32(item_q.coord_x);
            mul_b   = mag32(item_q.coord_x);
            mul_neg = 1'b0;
          end
          MOM_SUMWY: begin
            mul_a   = w_mag;
            mul_b   = mag32(item_q.coord_y);
            mul_neg = item_q.weight[31] ^ item_q.coord_y[31];
          end
          MOM_SUMWY2: begin
            mul_a   = mag32(item_q.coord_y);
            mul_b   = mag32(item_q.coord_y);
            mul_neg = 1'b0;
          end
          MOM_SUMWXY: begin
            mul_a   = mag32(item_q.coord_x);
            mul_b   = mag32(item_q.coord_y);
            mul_neg = item_q.coord_x[31] ^ item_q.coord_y[31];
          end
          default: begin
          end
        endcase
        state_d = sat_path ? S_MULLO : S_MADD;
      end

      // Floor-shifted square or cross term times the weight, low half.
      S_MULLO: begin
        s_val   = prod[63:COORD_FRAC];
        s_mag   = s_val[SHIFT_W-1] ? SHIFT_W'(-s_val) : s_val;
        neg_d   = item_q.weight[31] ^ s_val[SHIFT_W-1];
        shi_d   = s_mag[SHIFT_W-1:32];
        mul_en  = 1'b1;
        mul_a   = w_mag;
        mul_b   = s_mag[31:0];
        state_d = S_MULHI;
      end

      // High half of the same product.
      S_MULHI: begin
        lo_d    = prod;
        mul_en  = 1'b1;
        mul_a   = w_mag;
        mul_b   = 32'(shi_q);
        state_d = S_SATX;
      end

      // Combine the partial products and saturate to 64 bits.
      S_SATX: begin
        wide_p = {32'd0, lo_q} + {prod, 32'd0};
        if (!neg_q) begin
          term_d = (wide_p[95:63] != '0) ? ACC_MAX : wide_p[63:0];
        end else if ((wide_p[95:64] != '0) || (wide_p[63] && (wide_p[62:0] != '0))) begin
          term_d = ACC_MIN;
        end else begin
          term_d = 64'(-wide_p[63:0]);
        end
        state_d = S_MADD;
      end

      // Saturating accumulate into the current moment.
      S_MADD: begin
        term = sat_path ? term_q : prod;
        sum  = {acc_q[mi_q][63], acc_q[mi_q]} + {term[63], term};
        if (sum[64] != sum[63]) begin
          acc_d[mi_q] = sum[64] ? ACC_MIN : ACC_MAX;
        end else begin
          acc_d[mi_q] = sum[63:0];
        end
        if (mi_q == MOM_SUMWXY) begin
          state_d = S_EMIT;
        end else begin
          mi_d    = mom_e'(3'(mi_q + 3'd1));
          state_d = S_MUL1;
        end
      end

      // Hand the result to the output register.
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Axis finished: store its bin and move to the next axis.
    if (axis_done) begin
      if (!ax_q) begin
        bx_d = axis_res;
      end else begin
        by_d = axis_res;
      end
      if (!ax_q && (AXES >= 2)) begin
        ax_d    = 1'b1;
        state_d = S_AXIS;
      end else begin
        state_d = S_FLAT;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      for (int i = 0; i < MOMENTS; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      acc_q   <= acc_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    ax_q      <= ax_d;
    bx_q      <= bx_d;
    by_q      <= by_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    quo_q     <= quo_d;
    step_q    <= step_d;
    below_q   <= below_d;
    above_q   <= above_d;
    mid_q     <= mid_d;
    flat_q    <= flat_d;
    rd_only_q <= rd_only_d;
    inr_q     <= inr_d;
    res_q     <= res_d;
    mi_q      <= mi_d;
    neg_q     <= neg_d;
    shi_q     <= shi_d;
    lo_q      <= lo_d;
    term_q    <= term_d;
  end

  assign res_o = res_q;

endmodule

// ===== design/histogram_fill_engine.sv =====
// A fill bins each axis (flow bin directly, uniform by scaling and division, searched by edge
// search), updates the bin and, in range, the moments, then waits on the output. Read bin reads
// the store, read moment an accumulator; load writes an edge; clear zeroes bins and moments.
// One item at a time, set by the shared divider, edge search and moment multiplier.
// Reset is asynchronous, active low; the bin store is then swept to zero, and during the sweep
// no item is taken, while configuration writes are accepted throughout.
module histogram_fill_engine
  import hfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  hfe_cfg_if.sink   cfg_i,
  hfe_in_if.sink    in_i,
  hfe_out_if.source out_o
);

  cfg_t  cfg_d, cfg_q;
  logic  out_valid_d, out_valid_q;
  res_t  out_res_q;
  item_t in_item;
  logic  res_valid, res_ready;
  res_t  res;

  // Configuration register writes.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BINS_X:       cfg_d.bins_x        = cfg_i.data[4:0];
        CFG_BINS_Y:       cfg_d.bins_y        = cfg_i.data[4:0];
        CFG_X_LOW:        cfg_d.x_low         = cfg_i.data;
        CFG_X_HIGH:       cfg_d.x_high        = cfg_i.data;
        CFG_Y_LOW:        cfg_d.y_low         = cfg_i.data;
        CFG_Y_HIGH:       cfg_d.y_high        = cfg_i.data;
        CFG_VARIABLE:     cfg_d.variable_axes = cfg_i.data[1:0];
        CFG_CONTENT_MODE: cfg_d.content_mode  = cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Input item packing.
  always_comb begin
    in_item.kind          = in_i.kind;
    in_item.coord_x       = in_i.coord_x;
    in_item.coord_y       = in_i.coord_y;
    in_item.weight        = in_i.weight;
    in_item.edge_axis     = in_i.edge_axis;
    in_item.edge_slot     = in_i.edge_slot;
    in_item.edge_value    = in_i.edge_value;
    in_item.bin_address   = in_i.bin_address;
    in_item.moment_select = in_i.moment_select;
  end

  hfe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register decouples the core from the result consumer.
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bins_x        <= 5'd30;
      cfg_q.bins_y        <= 5'd30;
      cfg_q.x_low         <= 32'sd0;
      cfg_q.x_high        <= 32'sd65536;
      cfg_q.y_low         <= 32'sd0;
      cfg_q.y_high        <= 32'sd65536;
      cfg_q.variable_axes <= 2'd0;
      cfg_q.content_mode  <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.flat_bin     = out_res_q.flat_bin;
  assign out_o.in_range     = out_res_q.in_range;
  assign out_o.bin_content  = out_res_q.bin_content;
  assign out_o.moment_value = out_res_q.moment_value;

endmodule

// ===== sim/hfe_checker.sv =====
// Checker that watches the engine's channels, predicts its results and compares them.
`timescale 1ns / 100ps

module hfe_checker
  import hfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hfe_cfg_if.sink  cfg_mon,
  hfe_in_if.sink   in_mon,
  hfe_out_if.sink  out_mon,
  output int       fail_count_o,
  output int       pending_o
);

  // Predicted copy of the configuration and of the storage.
  logic [4:0]         bins_x_q, bins_y_q;
  logic signed [31:0] x_low_q, x_high_q, y_low_q, y_high_q;
  logic [1:0]         variable_q;
  logic               mode_q;
  logic [31:0]        bin_model [STORE_DEPTH];
  logic [31:0]        edge_model [EDGE_DEPTH];
  logic signed [63:0] moment_model [MOMENTS];
  res_t               expected_results [$];

  assign pending_o = expected_results.size();

  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return ACC_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return ACC_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] mul_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    if (p > 128'sh7fff_ffff_ffff_ffff) return ACC_MAX;
    if (p < -128'sh8000_0000_0000_0000) return ACC_MIN;
    return p[63:0];
  endfunction

  // Arithmetic shift is a floor division by two to the fraction width.
  function automatic logic signed [63:0] frac_floor(input logic signed [63:0] v);
    return v >>> COORD_FRAC;
  endfunction

  function automatic int clamp_bins(input logic [4:0] r);
    if (r == 0) return 1;
    if (r > MAX_BINS) return MAX_BINS;
    return r;
  endfunction

  // Bin of one axis: flow bins outside, division or edge search inside.
  function automatic int axis_bin(input int axis, input logic signed [31:0] c, input int n,
                                  input logic signed [31:0] lo, input logic signed [31:0] hi,
                                  input logic searched);
    longint d, w;
    int below, above, mid, slot;
    logic signed [31:0] e;
    if (c < lo) return 0;
    if (c >= hi) return n + 1;
    if (!searched) begin
      d = longint'(c) - longint'(lo);
      w = longint'(hi) - longint'(lo);
      return 1 + int'((longint'(n) * d) / w);
    end
    below = 0;
    above = n + 1;
    while (above - below > 1) begin
      mid = (above + below) / 2;
      slot = (mid - 1 > EDGE_SLOTS - 1) ? EDGE_SLOTS - 1 : mid - 1;
      e = edge_model[axis * EDGE_SLOTS + slot];
      if (c == e) return mid;
      if (c < e) above = mid;
      else below = mid;
    end
    return below;
  endfunction

  function automatic logic signed [31:0] content_view(input logic [31:0] raw);
    return mode_q ? 32'(signed'(raw[15:0])) : signed'(raw);
  endfunction

  // Appends one predicted result item to the tail of the queue.
  task automatic add_expected(input res_t r);
    expected_results = {expected_results, r};
  endtask

  // Applies one accepted item to the predicted state.
  task automatic predict_item(input item_t it);
    res_t r;
    int nx, ny, bx, by;
    logic inr;
    logic [9:0] flat;
    longint v, lim, x, y, w;
    r = '0;
    case (it.kind)
      KIND_FILL: begin
        x = it.coord_x;
        y = it.coord_y;
        w = it.weight;
        nx = clamp_bins(bins_x_q);
        ny = clamp_bins(bins_y_q);
        bx = axis_bin(0, it.coord_x, nx, x_low_q, x_high_q, variable_q[0]);
        by = axis_bin(1, it.coord_y, ny, y_low_q, y_high_q, variable_q[1]);
        inr = bx >= 1 && bx <= nx && by >= 1 && by <= ny;
        flat = 10'(by * (nx + 2) + bx);
        lim = mode_q ? longint'(SHORT_LIMIT) : longint'(LONG_LIMIT);
        v = longint'(content_view(bin_model[flat])) + w;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        bin_model[flat] = 32'(v);
        if (inr) begin
          moment_model[MOM_SUMW]   = add_sat64(moment_model[MOM_SUMW], w);
          moment_model[MOM_SUMW2]  = add_sat64(moment_model[MOM_SUMW2], w * w);
          moment_model[MOM_SUMWX]  = add_sat64(moment_model[MOM_SUMWX], w * x);
          moment_model[MOM_SUMWX2] = add_sat64(moment_model[MOM_SUMWX2],
                                               mul_sat64(w, frac_floor(x * x)));
          moment_model[MOM_SUMWY]  = add_sat64(moment_model[MOM_SUMWY], w * y);
          moment_model[MOM_SUMWY2] = add_sat64(moment_model[MOM_SUMWY2],
                                               mul_sat64(w, frac_floor(y * y)));
          moment_model[MOM_SUMWXY] = add_sat64(moment_model[MOM_SUMWXY],
                                               mul_sat64(w, frac_floor(x * y)));
        end
        r.flat_bin = flat;
        r.in_range = inr;
        r.bin_content = 32'(v);
        add_expected(r);
      end
      KIND_LOAD: edge_model[{it.edge_axis, it.edge_slot}] = it.edge_value;
      KIND_READ_BIN: begin
        r.flat_bin = it.bin_address;
        r.bin_content = content_view(bin_model[it.bin_address]);
        add_expected(r);
      end
      KIND_READ_MOM: begin
        if (it.moment_select < MOMENTS) r.moment_value = moment_model[it.moment_select];
        add_expected(r);
      end
      KIND_CLEAR: begin
        foreach (bin_model[i]) bin_model[i] = '0;
        foreach (moment_model[i]) moment_model[i] = '0;
      end
      default: ;
    endcase
  endtask

  // Watches the three channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    res_t got, want;
    if (!rst_ni) begin
      bins_x_q = 5'd30;
      bins_y_q = 5'd30;
      x_low_q = 0;
      x_high_q = 65536;
      y_low_q = 0;
      y_high_q = 65536;
      variable_q = '0;
      mode_q = 1'b0;
      foreach (bin_model[i]) bin_model[i] = '0;
      foreach (edge_model[i]) edge_model[i] = '0;
      foreach (moment_model[i]) moment_model[i] = '0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.flat_bin, out_mon.in_range, out_mon.bin_content,
                out_mon.moment_value};
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.flat_bin !== want.flat_bin) begin
            $error("flat_bin expected %0d actual %0d", want.flat_bin, got.flat_bin);
            fail_count_o++;
          end
          if (got.in_range !== want.in_range) begin
            $error("in_range expected %0d actual %0d", want.in_range, got.in_range);
            fail_count_o++;
          end
          if (got.bin_content !== want.bin_content) begin
            $error("bin_content expected %0d actual %0d", want.bin_content,
                   got.bin_content);
            fail_count_o++;
          end
          if (got.moment_value !== want.moment_value) begin
            $error("moment_value expected %0d actual %0d", want.moment_value,
                   got.moment_value);
            fail_count_o++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_BINS_X:       bins_x_q = cfg_mon.data[4:0];
          CFG_BINS_Y:       bins_y_q = cfg_mon.data[4:0];
          CFG_X_LOW:        x_low_q = cfg_mon.data;
          CFG_X_HIGH:       x_high_q = cfg_mon.data;
          CFG_Y_LOW:        y_low_q = cfg_mon.data;
          CFG_Y_HIGH:       y_high_q = cfg_mon.data;
          CFG_VARIABLE:     variable_q = cfg_mon.data[1:0];
          CFG_CONTENT_MODE: mode_q = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        it = '{in_mon.kind, in_mon.coord_x, in_mon.coord_y, in_mon.weight,
               in_mon.edge_axis, in_mon.edge_slot, in_mon.edge_value,
               in_mon.bin_address, in_mon.moment_select};
        predict_item(it);
      end
    end
  end

endmodule

// ===== sim/histogram_fill_engine_test.sv =====
// Testbench top: drives fill, edge, read and clear items and gives the verdict.
`timescale 1ns / 100ps

module histogram_fill_engine_test;
  import hfe_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic edges_loaded;

  hfe_cfg_if cfg_ch ();
  hfe_in_if  in_ch ();
  hfe_out_if out_ch ();

  histogram_fill_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  hfe_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch.sink),
    .in_mon       (in_ch.sink),
    .out_mon      (out_ch.sink),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver stalls at random on the falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one configuration write and waits for its acceptance.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sends one item after an optional random gap; valid stays high until the next
  // item, a gap or the drain takes it down.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.coord_x <= it.coord_x;
    in_ch.coord_y <= it.coord_y;
    in_ch.weight <= it.weight;
    in_ch.edge_axis <= it.edge_axis;
    in_ch.edge_slot <= it.edge_slot;
    in_ch.edge_value <= it.edge_value;
    in_ch.bin_address <= it.bin_address;
    in_ch.moment_select <= it.moment_select;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Waits until every expected result has come, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (1100) @(negedge clk_i);
  endtask

  // Random item; fills land mostly near the axis range.
  function automatic item_t random_item(input logic signed [31:0] lo,
                                        input logic signed [31:0] hi);
    item_t it;
    int sel;
    it = '{default: '0};
    it.coord_x = $urandom();
    it.coord_y = $urandom();
    it.weight = $urandom();
    it.edge_axis = $urandom_range(1);
    it.edge_slot = $urandom();
    it.edge_value = $urandom();
    it.bin_address = $urandom();
    it.moment_select = $urandom();
    sel = $urandom_range(99);
    if (sel < 70) begin
      it.kind = KIND_FILL;
      if ($urandom_range(9) < 8) begin
        it.coord_x = lo + 32'($urandom_range(32'(hi - lo + 4))) - 2;
        it.coord_y = lo + 32'($urandom_range(32'(hi - lo + 4))) - 2;
      end
      if ($urandom_range(3) != 0) it.weight = $signed($urandom_range(2000)) - 1000;
      if (it.weight == 32'sh8000_0000) it.weight = 32'sh8000_0001;
    end else if (sel < 85) begin
      it.kind = KIND_READ_BIN;
    end else if (sel < 95) begin
      it.kind = KIND_READ_MOM;
    end else if (sel < 97) begin
      it.kind = KIND_CLEAR;
    end else if (sel < 98) begin
      it.kind = 3'($urandom_range(7, 5));
    end else begin
      it.kind = KIND_LOAD;
      it.edge_value = lo + 32'((longint'(hi) - longint'(lo)) * it.edge_slot / 32);
      if (!edges_loaded) it.kind = KIND_READ_BIN;
    end
    return it;
  endfunction

  // Loads ascending edges spread over lo..hi on both axes.
  task automatic load_edges(input logic signed [31:0] lo, input logic signed [31:0] hi);
    item_t it;
    it = '{default: '0};
    it.kind = KIND_LOAD;
    for (int a = 0; a < 2; a++) begin
      for (int s = 0; s < EDGE_SLOTS; s++) begin
        it.edge_axis = a;
        it.edge_slot = s;
        it.edge_value = lo + 32'((longint'(hi) - longint'(lo)) * s / 31);
        send_item(it);
      end
    end
    edges_loaded = 1'b1;
  endtask

  task automatic set_axes(input logic [4:0] nx, input logic [4:0] ny,
                          input logic signed [31:0] lo, input logic signed [31:0] hi,
                          input logic [1:0] var_axes, input logic mode);
    write_reg(CFG_BINS_X, 32'(nx));
    write_reg(CFG_BINS_Y, 32'(ny));
    write_reg(CFG_X_LOW, lo);
    write_reg(CFG_X_HIGH, hi);
    write_reg(CFG_Y_LOW, lo);
    write_reg(CFG_Y_HIGH, hi);
    write_reg(CFG_VARIABLE, 32'(var_axes));
    write_reg(CFG_CONTENT_MODE, 32'(mode));
  endtask

  // Directed fill at given coordinates and weight.
  task automatic fill_at(input logic [31:0] x, input logic [31:0] y, input logic [31:0] w);
    item_t it;
    it = '{default: '0};
    it.kind = KIND_FILL;
    it.coord_x = x;
    it.coord_y = y;
    it.weight = w;
    send_item(it);
  endtask

  // Stimulus.
  initial begin
    item_t it;
    logic signed [31:0] lo, hi;
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.weight = '0;
    in_ch.edge_axis = '0;
    in_ch.edge_slot = '0;
    in_ch.edge_value = '0;
    in_ch.bin_address = '0;
    in_ch.moment_select = '0;
    out_ch.ready = 1'b0;
    edges_loaded = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 53;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, saturation, flow bins, every kind except the edge load.
    fill_at(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    fill_at(32'h0000_8000, 32'h0000_8000, 32'h7fff_ffff);
    fill_at(32'h0000_8000, 32'h0000_8000, 32'h7fff_ffff);
    fill_at(32'h0000_8000, 32'h0000_8000, 32'h8000_0001);
    fill_at(32'h0000_0000, 32'h0000_ffff, 32'h8000_0001);
    fill_at(32'h0001_0000, 32'hffff_ffff, 32'd5);
    it = '{default: '0};
    it.kind = KIND_READ_BIN;
    it.bin_address = 10'h3ff;
    send_item(it);
    it.bin_address = 10'd0;
    send_item(it);
    it.kind = KIND_READ_MOM;
    for (int m = 0; m < 8; m++) begin
      it.moment_select = m;
      send_item(it);
    end
    it.kind = 3'd7;
    send_item(it);
    it.kind = KIND_CLEAR;
    send_item(it);
    it.kind = KIND_READ_MOM;
    it.moment_select = MOM_SUMW;
    send_item(it);
    drain();

    // Big coordinates so the moment products saturate; 16-bit contents; inverted range.
    set_axes(5'd0, 5'd31, 32'sh8000_0000, 32'sh7fff_ffff, 2'b00, 1'b1);
    fill_at(32'h7fff_0000, 32'h8000_0000, 32'h7fff_ffff);
    fill_at(32'h7fff_0000, 32'h7fff_0000, 32'h7fff_ffff);
    fill_at(32'h7fff_0000, 32'h7fff_0000, 32'h7fff_ffff);
    drain();
    set_axes(5'd7, 5'd3, 32'sh0001_0000, 32'sh0000_0000, 2'b00, 1'b0);
    fill_at(32'h0000_8000, 32'h0000_8000, 32'd3);
    drain();

    // Random phases over several settings, idling pattern switching as it goes.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 53;
        recv_idle_pct = 7;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase % 3)
        0: begin lo = -32'sd65536; hi = 32'sd65536; end
        1: begin lo = 32'sh8000_0000; hi = 32'sh7fff_ffff; end
        default: begin lo = 32'sd1000; hi = 32'sd5000; end
      endcase
      set_axes(5'($urandom_range(31)), 5'($urandom_range(31)), lo, hi,
               2'($urandom_range(3)), 1'($urandom_range(1)));
      if (phase < 4) write_reg(CFG_BINS_X, 32'(phase == 0 ? 1 : 30));
      load_edges(lo, hi);
      for (int n = 0; n < 260; n++) send_item(random_item(lo, hi));
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS histogram_fill_engine");
    end else begin
      $display("FAIL histogram_fill_engine");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20000000;
    $display("FAIL histogram_fill_engine");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hfe_pkg.sv
design/hfe_if.sv
design/hfe_ram.sv
design/hfe_mul.sv
design/hfe_core.sv
design/histogram_fill_engine.sv
sim/hfe_checker.sv
sim/histogram_fill_engine_test.sv
